// File: hdl/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("check failed: label");
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("check failed: label");
`endif

// File: hdl/rmrd_pkg.sv
// Shared constants and types for the retry and duplicate-filter core.
// No dependencies.
package rmrd_pkg;
  localparam int RETRY_SLOTS_DEF  = 16;
  localparam int SEEN_SLOTS_DEF   = 64;
  localparam int SWEEP_PERIOD_DEF = 16;
  localparam int ID_BITS_DEF      = 24;
  localparam int PEER_W = 48;
  localparam int MID_W  = 24;
  localparam int LIM_W  = 8;
  localparam int TIME_W = 32;
  localparam int SLOT_W = 4;
  localparam logic [TIME_W-1:0] MAX_AGE_RST = 32'd600;

  typedef enum logic [1:0] {
    MODE_SEND = 2'd0, MODE_ACK = 2'd1, MODE_DATA = 2'd2, MODE_TICK = 2'd3
  } mode_t;
  typedef enum logic [1:0] {
    KIND_TX = 2'd0, KIND_SACK = 2'd1, KIND_MATCH = 2'd2, KIND_FULL = 2'd3
  } kind_t;
endpackage

// File: hdl/rmrd_if.sv
// Valid/ready channel interfaces for requests, results and configuration.
// Depends on rmrd_pkg.
interface rmrd_in_if;
  logic valid;
  logic ready;
  logic [1:0] mode;
  logic [rmrd_pkg::PEER_W-1:0] endpoint;
  logic [rmrd_pkg::MID_W-1:0] rx_id;
  logic [rmrd_pkg::LIM_W-1:0] retry_limit;
  modport source (output valid, mode, endpoint, rx_id, retry_limit, input ready);
  modport sink (input valid, mode, endpoint, rx_id, retry_limit, output ready);
endinterface

interface rmrd_out_if;
  logic valid;
  logic ready;
  logic [1:0] kind;
  logic [rmrd_pkg::PEER_W-1:0] peer;
  logic [rmrd_pkg::MID_W-1:0] msg_id;
  logic [rmrd_pkg::SLOT_W-1:0] slot;
  logic deliver;
  logic discarded;
  logic last;
  modport source (output valid, kind, peer, msg_id, slot, deliver, discarded, last,
                  input ready);
  modport sink (input valid, kind, peer, msg_id, slot, deliver, discarded, last,
                output ready);
endinterface

interface rmrd_cfg_if;
  logic valid;
  logic ready;
  logic [rmrd_pkg::TIME_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// File: hdl/rmrd_seen.sv
// Seen table: sequential lookup, record and aged sweep over a memory.
// Depends on rmrd_pkg.
module rmrd_seen #(
  parameter int SEEN_SLOTS = rmrd_pkg::SEEN_SLOTS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic look_go,
  input  logic sweep_go,
  input  logic [rmrd_pkg::PEER_W-1:0] key_peer,
  input  logic [rmrd_pkg::MID_W-1:0]  key_id,
  input  logic [rmrd_pkg::TIME_W-1:0] now,
  input  logic [rmrd_pkg::TIME_W-1:0] max_age,
  output logic done,
  output logic hit,
  output logic full
);
  localparam int IW = (SEEN_SLOTS > 1) ? $clog2(SEEN_SLOTS) : 1;
  localparam int CW = $clog2(SEEN_SLOTS + 1);
  localparam int EW = rmrd_pkg::PEER_W + rmrd_pkg::MID_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_LOOK = 4'b0010, S_SWEEP = 4'b0100, S_DONE = 4'b1000
  } sst_t;

  logic [EW-1:0] key_mem [SEEN_SLOTS];
  logic [rmrd_pkg::TIME_W-1:0] time_mem [SEEN_SLOTS];
  logic [SEEN_SLOTS-1:0] valid_r, valid_nxt;
  sst_t st_r, st_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [IW-1:0] hit_idx_r, hit_idx_nxt, free_idx_r, free_idx_nxt;
  logic hit_r, hit_nxt, free_r, free_nxt;
  logic [EW-1:0] rd_key_r;
  logic [rmrd_pkg::TIME_W-1:0] rd_time_r;
  logic rd_v_r, rd_v_nxt;
  logic [IW-1:0] rd_idx_r;
  logic wr_en;
  logic [IW-1:0] wr_idx;
  logic rd_req;
  logic [IW-1:0] ridx;

  assign ridx = idx_r[IW-1:0];
  assign rd_req = (st_r == S_LOOK || st_r == S_SWEEP) && (idx_r < CW'(SEEN_SLOTS));

  // memory read, one entry per cycle, registered; key written only for a new pair
  always_ff @(posedge clk) begin
    if (rd_req) begin
      rd_key_r  <= key_mem[ridx];
      rd_time_r <= time_mem[ridx];
      rd_idx_r  <= ridx;
    end
    if (wr_en && !hit_r) key_mem[wr_idx] <= {key_peer, key_id};
    if (wr_en) time_mem[wr_idx] <= now;
  end

  always_comb begin
    st_nxt = st_r; idx_nxt = idx_r; valid_nxt = valid_r;
    hit_nxt = hit_r; free_nxt = free_r; hit_idx_nxt = hit_idx_r;
    free_idx_nxt = free_idx_r; rd_v_nxt = rd_req;
    wr_en = 1'b0; wr_idx = hit_r ? hit_idx_r : free_idx_r;
    case (st_r)
      S_IDLE: begin
        rd_v_nxt = 1'b0;
        // lookup flags stay readable until the next walk starts
        if (look_go || sweep_go) begin
          idx_nxt = '0; hit_nxt = 1'b0; free_nxt = 1'b0;
        end
        if (look_go) st_nxt = S_LOOK;
        else if (sweep_go) st_nxt = S_SWEEP;
      end
      S_LOOK: begin
        if (idx_r < CW'(SEEN_SLOTS)) idx_nxt = idx_r + 1'b1;
        if (rd_v_r) begin
          if (valid_r[rd_idx_r]) begin
            if (!hit_r && rd_key_r == {key_peer, key_id}) begin
              hit_nxt = 1'b1; hit_idx_nxt = rd_idx_r;
            end
          end else if (!free_r) begin
            free_nxt = 1'b1; free_idx_nxt = rd_idx_r;
          end
        end
        if (!rd_req && !rd_v_r) begin
          st_nxt = S_DONE;
          if (hit_r || free_r) begin
            wr_en = 1'b1;
            valid_nxt[wr_idx] = 1'b1;
          end
        end
      end
      S_SWEEP: begin
        if (idx_r < CW'(SEEN_SLOTS)) idx_nxt = idx_r + 1'b1;
        if (rd_v_r && valid_r[rd_idx_r] && (now - rd_time_r) > max_age)
          valid_nxt[rd_idx_r] = 1'b0;
        if (!rd_req && !rd_v_r) st_nxt = S_DONE;
      end
      S_DONE: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; valid_r <= '0; rd_v_r <= 1'b0; idx_r <= '0;
      hit_r <= 1'b0; free_r <= 1'b0;
    end else begin
      st_r <= st_nxt; valid_r <= valid_nxt; rd_v_r <= rd_v_nxt; idx_r <= idx_nxt;
      hit_r <= hit_nxt; free_r <= free_nxt;
    end
    hit_idx_r <= hit_idx_nxt; free_idx_r <= free_idx_nxt;
  end

  assign done = (st_r == S_DONE);
  assign hit  = hit_r;
  assign full = !hit_r && !free_r;
endmodule

// File: hdl/reliable_message_retry_and_dedup_core.sv
// Retry table with ack matching and duplicate filter: top level.
// Depends on rmrd_pkg, rmrd_if and rmrd_seen.
// A send or ack/tick scans the retry table and data walks the seen table before its result;
// a result held back by out_ready stalls the core until it is taken.
// One item at a time; a tick reaching a multiple of SWEEP_PERIOD adds a seen-table sweep.
// Sync active-low reset clears valid bits, time, next id and sets max_age_r to 600.
module reliable_message_retry_and_dedup_core #(
  parameter int RETRY_SLOTS  = rmrd_pkg::RETRY_SLOTS_DEF,
  parameter int SEEN_SLOTS   = rmrd_pkg::SEEN_SLOTS_DEF,
  parameter int SWEEP_PERIOD = rmrd_pkg::SWEEP_PERIOD_DEF,
  parameter int ID_BITS      = rmrd_pkg::ID_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  rmrd_in_if.sink    in_ch,
  rmrd_out_if.source out_ch,
  rmrd_cfg_if.sink   cfg_ch
);
  localparam int SW = (RETRY_SLOTS > 1) ? $clog2(RETRY_SLOTS) : 1;
  localparam int CW = $clog2(RETRY_SLOTS + 1);
  localparam int PW = (SWEEP_PERIOD > 1) ? $clog2(SWEEP_PERIOD) : 1;

  typedef enum logic [6:0] {
    T_IDLE = 7'b0000001, T_SCAN = 7'b0000010, T_EMIT = 7'b0000100,
    T_SEEN = 7'b0001000, T_SACK = 7'b0010000, T_FULL = 7'b0100000,
    T_SWP  = 7'b1000000
  } st_t;

  st_t st_r, st_nxt;
  logic [1:0] mode_r;
  logic [rmrd_pkg::PEER_W-1:0] ep_r;
  logic [rmrd_pkg::MID_W-1:0] mid_r;
  logic [rmrd_pkg::LIM_W-1:0] lim_r;
  logic [RETRY_SLOTS-1:0] sv_r, sv_nxt;
  logic [ID_BITS-1:0] sid_r [RETRY_SLOTS];
  logic [rmrd_pkg::PEER_W-1:0] speer_r [RETRY_SLOTS];
  logic [rmrd_pkg::LIM_W-1:0] sret_r [RETRY_SLOTS];
  logic [ID_BITS-1:0] next_id_r;
  logic [rmrd_pkg::TIME_W-1:0] now_r, max_age_r;
  logic [PW-1:0] phase_r;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [SW-1:0] cur;
  logic free_f_r; logic [SW-1:0] free_i_r;
  logic [rmrd_pkg::LIM_W-1:0] dec;
  logic sweep_due_r;
  // output register
  logic ov_r; logic [1:0] ok_r; logic [rmrd_pkg::PEER_W-1:0] op_r;
  logic [rmrd_pkg::MID_W-1:0] om_r; logic [rmrd_pkg::SLOT_W-1:0] os_r;
  logic od_r, ox_r, ol_r;
  logic in_xfer, out_free, seen_done, seen_hit, seen_full, look_go, sweep_go;
  logic scan_hit, res_load;

  assign cur = idx_r[SW-1:0];
  assign in_xfer = in_ch.valid && in_ch.ready;
  assign out_free = !ov_r || out_ch.ready;
  assign in_ch.ready = (st_r == T_IDLE) && !ov_r;
  assign cfg_ch.ready = 1'b1;
  assign dec = (sret_r[cur] != '0) ? sret_r[cur] - 1'b1 : sret_r[cur];
  assign look_go = (st_r == T_IDLE) && in_xfer &&
                   in_ch.mode == rmrd_pkg::MODE_DATA;
  assign sweep_go = (st_r == T_SWP) && (idx_r == '0);

  // current slot yields an ack match or a retransmit
  assign scan_hit = (st_r == T_SCAN) && (mode_r != rmrd_pkg::MODE_SEND) &&
                    (idx_r != CW'(RETRY_SLOTS)) && sv_r[cur] &&
                    (mode_r == rmrd_pkg::MODE_TICK ||
                     rmrd_pkg::MID_W'(sid_r[cur]) == mid_r);
  assign res_load = out_free && (scan_hit || st_r == T_EMIT || st_r == T_SACK ||
                                 st_r == T_FULL);

  rmrd_seen #(.SEEN_SLOTS(SEEN_SLOTS)) u_seen (
    .clk(clk), .rst_n(rst_n), .look_go(look_go), .sweep_go(sweep_go),
    .key_peer(ep_r), .key_id(mid_r), .now(now_r), .max_age(max_age_r),
    .done(seen_done), .hit(seen_hit), .full(seen_full)
  );

  // later matching slot exists after cur (for last flag on ack/tick)
  function automatic logic more_after(input logic [RETRY_SLOTS-1:0] v,
                                      input logic [CW-1:0] from, input logic is_ack,
                                      input logic [ID_BITS-1:0] ids [RETRY_SLOTS],
                                      input logic [rmrd_pkg::MID_W-1:0] m);
    logic r;
    r = 1'b0;
    for (int k = 0; k < RETRY_SLOTS; k++)
      if (CW'(k) > from && v[k] && (!is_ack || rmrd_pkg::MID_W'(ids[k]) == m)) r = 1'b1;
    return r;
  endfunction

  always_comb begin
    st_nxt = st_r; idx_nxt = idx_r; sv_nxt = sv_r;
    case (st_r)
      T_IDLE: if (in_xfer) begin
        idx_nxt = '0;
        st_nxt = (in_ch.mode == rmrd_pkg::MODE_DATA) ? T_SEEN : T_SCAN;
      end
      T_SCAN: begin
        if (mode_r == rmrd_pkg::MODE_SEND) begin
          if (idx_r == CW'(RETRY_SLOTS) || free_f_r) st_nxt = T_EMIT;
          else idx_nxt = idx_r + 1'b1;
        end else if (idx_r == CW'(RETRY_SLOTS)) begin
          st_nxt = (mode_r == rmrd_pkg::MODE_TICK && sweep_due_r) ? T_SWP : T_IDLE;
          idx_nxt = '0;
        end else if (sv_r[cur] && (mode_r == rmrd_pkg::MODE_TICK ||
                     rmrd_pkg::MID_W'(sid_r[cur]) == mid_r)) begin
          if (out_free) begin
            idx_nxt = idx_r + 1'b1;
            if (mode_r == rmrd_pkg::MODE_ACK || dec == '0) sv_nxt[cur] = 1'b0;
          end
        end else idx_nxt = idx_r + 1'b1;
      end
      T_EMIT: if (out_free) begin
        st_nxt = T_IDLE;
        if (free_f_r) sv_nxt[free_i_r] = 1'b1;
      end
      T_SEEN: if (seen_done) st_nxt = T_SACK;
      T_SACK: if (out_free) st_nxt = seen_full ? T_FULL : T_IDLE;
      T_FULL: if (out_free) st_nxt = T_IDLE;
      T_SWP: begin
        idx_nxt = CW'(1);
        if (idx_r != '0 && seen_done) st_nxt = T_IDLE;
      end
      default: st_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= T_IDLE; sv_r <= '0; next_id_r <= '0; now_r <= '0; phase_r <= '0;
      max_age_r <= rmrd_pkg::MAX_AGE_RST; ov_r <= 1'b0; idx_r <= '0;
      free_f_r <= 1'b0; sweep_due_r <= 1'b0;
    end else begin
      st_r <= st_nxt; idx_r <= idx_nxt; sv_r <= sv_nxt;
      if (cfg_ch.valid) max_age_r <= cfg_ch.data;
      // result valid: set on a new result, cleared on its transfer
      if (res_load) ov_r <= 1'b1;
      else if (out_ch.ready) ov_r <= 1'b0;
      if (st_r == T_IDLE && in_xfer) begin
        free_f_r <= 1'b0;
        if (in_ch.mode == rmrd_pkg::MODE_TICK) begin
          now_r <= now_r + 1'b1;
          phase_r <= (phase_r == PW'(SWEEP_PERIOD - 1)) ? '0 : phase_r + 1'b1;
          sweep_due_r <= (phase_r == PW'(SWEEP_PERIOD - 1));
        end
      end
      // lowest free slot search for send
      if (st_r == T_SCAN && mode_r == rmrd_pkg::MODE_SEND &&
          idx_r != CW'(RETRY_SLOTS) && !free_f_r && !sv_r[cur]) begin
        free_f_r <= 1'b1;
      end
      if (st_r == T_EMIT && out_free && free_f_r) next_id_r <= next_id_r + 1'b1;
    end
    // payload
    if (st_r == T_IDLE && in_xfer) begin
      mode_r <= in_ch.mode; ep_r <= in_ch.endpoint;
      mid_r <= in_ch.rx_id; lim_r <= in_ch.retry_limit;
    end
    if (st_r == T_SCAN && mode_r == rmrd_pkg::MODE_SEND &&
        idx_r != CW'(RETRY_SLOTS) && !free_f_r && !sv_r[cur]) free_i_r <= cur;
    if (scan_hit && out_free && mode_r == rmrd_pkg::MODE_TICK) sret_r[cur] <= dec;
    if (scan_hit && out_free) begin
      ok_r <= (mode_r == rmrd_pkg::MODE_ACK) ? rmrd_pkg::KIND_MATCH : rmrd_pkg::KIND_TX;
      op_r <= speer_r[cur]; om_r <= rmrd_pkg::MID_W'(sid_r[cur]);
      os_r <= rmrd_pkg::SLOT_W'(cur); od_r <= 1'b0;
      ox_r <= (mode_r == rmrd_pkg::MODE_TICK) && (dec == '0);
      ol_r <= !more_after(sv_r, idx_r, mode_r == rmrd_pkg::MODE_ACK, sid_r, mid_r);
    end
    if (st_r == T_EMIT && out_free) begin
      ok_r <= free_f_r ? rmrd_pkg::KIND_TX : rmrd_pkg::KIND_FULL;
      op_r <= ep_r; om_r <= rmrd_pkg::MID_W'(next_id_r);
      os_r <= free_f_r ? rmrd_pkg::SLOT_W'(free_i_r) : '0;
      od_r <= 1'b0; ox_r <= 1'b0; ol_r <= 1'b1;
      if (free_f_r) begin
        sid_r[free_i_r] <= next_id_r; speer_r[free_i_r] <= ep_r;
        sret_r[free_i_r] <= lim_r;
      end
    end
    if (st_r == T_SACK && out_free) begin
      ok_r <= rmrd_pkg::KIND_SACK; op_r <= ep_r; om_r <= mid_r; os_r <= '0;
      od_r <= !seen_hit; ox_r <= 1'b0; ol_r <= !seen_full;
    end
    if (st_r == T_FULL && out_free) begin
      ok_r <= rmrd_pkg::KIND_FULL; op_r <= ep_r; om_r <= mid_r; os_r <= '0;
      od_r <= 1'b0; ox_r <= 1'b0; ol_r <= 1'b1;
    end
  end

  assign out_ch.valid = ov_r; assign out_ch.kind = ok_r; assign out_ch.peer = op_r;
  assign out_ch.msg_id = om_r; assign out_ch.slot = os_r; assign out_ch.deliver = od_r;
  assign out_ch.discarded = ox_r; assign out_ch.last = ol_r;
endmodule

// File: hdl/rmrd_checker.sv
// Port-level checker for the retry and dedup core, bound to the top level.
// Depends on assert_macros.svh and rmrd_pkg.
`include "assert_macros.svh"
module rmrd_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid, in_ready,
  input logic out_valid, out_ready,
  input logic [1:0] out_kind,
  input logic out_deliver, out_discarded
);
  `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `CHK_NEXT(a_busy_after_in, clk, rst_n, in_valid && in_ready, !in_ready)
  `CHK_IMPL(a_no_in_while_out, clk, rst_n, out_valid, !in_ready)
  `CHK_IMPL(a_deliver_sack, clk, rst_n, out_valid && out_deliver, out_kind == rmrd_pkg::KIND_SACK)
  `CHK_IMPL(a_discard_tx, clk, rst_n, out_valid && out_discarded, out_kind == rmrd_pkg::KIND_TX)
endmodule

bind reliable_message_retry_and_dedup_core rmrd_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_kind(out_ch.kind),
  .out_deliver(out_ch.deliver), .out_discarded(out_ch.discarded)
);
